// File: hdl/bounded_deque_engine_assert.svh
// -----------------------------------------------------------------------------
// bounded_deque_engine_assert.svh
// Assertion macros shared by the deque engine checkers.
// -----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_ENGINE_ASSERT_SVH
`define BOUNDED_DEQUE_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BDE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/bde_pkg.sv
// -----------------------------------------------------------------------------
// bde_pkg
// Shared types and codes of the bounded deque engine.
// -----------------------------------------------------------------------------
package bde_pkg;

    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    typedef logic [OPCODE_W-1:0]       t_opcode;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [COUNT_W-1:0]        t_count;

    localparam t_opcode OP_PUSH_FRONT = 3'd0;
    localparam t_opcode OP_PUSH_BACK  = 3'd1;
    localparam t_opcode OP_POP_FRONT  = 3'd2;
    localparam t_opcode OP_POP_BACK   = 3'd3;
    localparam t_opcode OP_REMOVE     = 3'd4;
    localparam t_opcode OP_REVERSE    = 3'd5;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

endpackage

// File: hdl/bde_if.sv
// -----------------------------------------------------------------------------
// bde_if
// Command and response channels of the bounded deque engine.
// -----------------------------------------------------------------------------
interface bde_cmd_if import bde_pkg::*; ();
    logic    valid;
    logic    ready;
    t_opcode opcode;
    t_value  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface bde_rsp_if import bde_pkg::*; ();
    logic    valid;
    logic    ready;
    t_status status;
    t_value  removed_value;
    t_count  element_count;

    modport source (output valid, output status, output removed_value,
                    output element_count, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input element_count, output ready);
endinterface

// File: hdl/bounded_deque_engine.sv
// -----------------------------------------------------------------------------
// bounded_deque_engine
// Bounded double-ended queue of signed values in a circular RAM.
// -----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one item: an opcode (push front/back, pop front/back,
//   remove first match, reverse) and a value. o_rsp returns exactly one item
//   per command: status, removed value and the element count afterwards.
//   Commands are handled one at a time; i_cmd.ready is high only while the
//   sequencer is idle. All element traffic goes through one RAM port pair
//   (one write, one registered read), so a remove scans from the front to
//   the first match and then shifts each later element down, and a reverse
//   swaps element pairs from both ends inward.
//   The response sits in an output register; the next command is taken
//   while it waits. If the receiver stalls, a finished command waits in its
//   final state until the output register frees up.
//   Reset clears the count, front pointer and control state; RAM contents
//   are not cleared and are never read before being written.
// -----------------------------------------------------------------------------
module bounded_deque_engine import bde_pkg::*; #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bde_cmd_if.sink   i_cmd,
    bde_rsp_if.source o_rsp
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CW1 = CW + 1;
    localparam logic [AW:0]   CAP_SUM = (AW+1)'(CAPACITY);
    localparam logic [AW-1:0] LAST    = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_SRCH,
        S_SHIFT,
        S_REV_B,
        S_REV_WA,
        S_REV_WB
    } t_state;

    localparam t_state S_DONE_CODE = S_IDLE;

    typedef enum logic {
        D_BUSY,
        D_DONE
    } t_done;

    t_state                r_state, n_state;
    t_done                 r_fin, n_fin;
    t_opcode               r_op, n_op;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [AW-1:0]         r_front, n_front;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_ptr_a, n_ptr_a;
    logic [AW-1:0]         r_ptr_b, n_ptr_b;
    logic [CW-1:0]         r_idx, n_idx;
    logic [DATA_WIDTH-1:0] r_tmp, n_tmp;
    t_status               r_status, n_status;
    t_value                r_removed, n_removed;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    t_value                r_out_removed, n_out_removed;
    t_count                r_out_count, n_out_count;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    logic [AW:0]           tail_sum;
    logic [AW-1:0]         tail;
    logic [CW1-1:0]        idx_p1;
    logic [CW1-1:0]        idx_p2;
    logic [CW1-1:0]        cnt_x;
    t_value                rd_ext;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST : p - AW'(1);
    endfunction

    bde_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // slot just past the back element
    always_comb begin
        tail_sum = {1'b0, r_front} + (AW+1)'(r_count);
        tail     = (tail_sum >= CAP_SUM) ? AW'(tail_sum - CAP_SUM) : AW'(tail_sum);
    end

    assign idx_p1 = CW1'(r_idx) + CW1'(1);
    assign idx_p2 = CW1'(r_idx) + CW1'(2);
    assign cnt_x  = CW1'(r_count);
    assign rd_ext = VALUE_W'($signed(mem_rdata));

    always_comb begin
        n_state       = r_state;
        n_fin         = D_BUSY;
        n_op          = r_op;
        n_val         = r_val;
        n_front       = r_front;
        n_count       = r_count;
        n_ptr_a       = r_ptr_a;
        n_ptr_b       = r_ptr_b;
        n_idx         = r_idx;
        n_tmp         = r_tmp;
        n_status      = r_status;
        n_removed     = r_removed;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_status  = r_out_status;
        n_out_removed = r_out_removed;
        n_out_count   = r_out_count;
        mem_we        = 1'b0;
        mem_waddr     = r_ptr_a;
        mem_wdata     = mem_rdata;
        mem_raddr     = r_ptr_a;

        case (r_state)
            S_IDLE: begin
                if (r_fin == D_DONE) begin
                    // hold the finished item until the output register frees
                    if (!r_out_valid || o_rsp.ready) begin
                        n_out_valid   = 1'b1;
                        n_out_status  = r_status;
                        n_out_removed = r_removed;
                        n_out_count   = COUNT_W'(r_count);
                    end else begin
                        n_fin = D_DONE;
                    end
                end else if (i_cmd.valid) begin
                    n_op      = i_cmd.opcode;
                    n_val     = DATA_WIDTH'(i_cmd.value);
                    n_status  = ST_OK;
                    n_removed = '0;
                    n_state   = S_DECODE;
                end
            end

            S_DECODE: begin
                n_state = S_DONE_CODE;
                n_fin   = D_DONE;
                case (r_op)
                    OP_PUSH_FRONT, OP_PUSH_BACK: begin
                        if (r_count == CAP_CNT) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_wdata = r_val;
                            n_count   = r_count + CW'(1);
                            if (r_op == OP_PUSH_FRONT) begin
                                mem_waddr = f_dec(r_front);
                                n_front   = f_dec(r_front);
                            end else begin
                                mem_waddr = tail;
                            end
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            mem_raddr = (r_op == OP_POP_FRONT) ? r_front : f_dec(tail);
                            n_state   = S_POP;
                            n_fin     = D_BUSY;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            mem_raddr = r_front;
                            n_ptr_a   = r_front;
                            n_idx     = '0;
                            n_state   = S_SRCH;
                            n_fin     = D_BUSY;
                        end
                    end
                    OP_REVERSE: begin
                        if (r_count > CW'(1)) begin
                            mem_raddr = r_front;
                            n_ptr_a   = r_front;
                            n_ptr_b   = f_dec(tail);
                            n_idx     = r_count >> 1;
                            n_state   = S_REV_B;
                            n_fin     = D_BUSY;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_POP: begin
                n_removed = rd_ext;
                n_count   = r_count - CW'(1);
                if (r_op == OP_POP_FRONT) begin
                    n_front = f_inc(r_front);
                end
                n_state = S_DONE_CODE;
                n_fin   = D_DONE;
            end

            // compare element idx while fetching idx + 1
            S_SRCH: begin
                mem_raddr = f_inc(r_ptr_a);
                if (mem_rdata == r_val) begin
                    n_removed = rd_ext;
                    if (idx_p1 < cnt_x) begin
                        n_state = S_SHIFT;
                    end else begin
                        n_count = r_count - CW'(1);
                        n_state = S_DONE_CODE;
                        n_fin   = D_DONE;
                    end
                end else if (idx_p1 == cnt_x) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE_CODE;
                    n_fin    = D_DONE;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_ptr_a = f_inc(r_ptr_a);
                end
            end

            // close the gap: move idx + 1 down to idx, fetch idx + 2
            S_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr_a;
                mem_wdata = mem_rdata;
                mem_raddr = f_inc(f_inc(r_ptr_a));
                n_ptr_a   = f_inc(r_ptr_a);
                n_idx     = r_idx + CW'(1);
                if (idx_p2 >= cnt_x) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE_CODE;
                    n_fin   = D_DONE;
                end
            end

            S_REV_B: begin
                n_tmp     = mem_rdata;
                mem_raddr = r_ptr_b;
                n_state   = S_REV_WA;
            end

            S_REV_WA: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr_a;
                mem_wdata = mem_rdata;
                n_state   = S_REV_WB;
            end

            // finish the swap and prefetch the next low element
            S_REV_WB: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr_b;
                mem_wdata = r_tmp;
                mem_raddr = f_inc(r_ptr_a);
                n_ptr_a   = f_inc(r_ptr_a);
                n_ptr_b   = f_dec(r_ptr_b);
                n_idx     = r_idx - CW'(1);
                if (r_idx == CW'(1)) begin
                    n_state = S_DONE_CODE;
                    n_fin   = D_DONE;
                end else begin
                    n_state = S_REV_B;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fin       <= D_BUSY;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fin       <= n_fin;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_op          <= n_op;
        r_val         <= n_val;
        r_ptr_a       <= n_ptr_a;
        r_ptr_b       <= n_ptr_b;
        r_idx         <= n_idx;
        r_tmp         <= n_tmp;
        r_status      <= n_status;
        r_removed     <= n_removed;
        r_out_status  <= n_out_status;
        r_out_removed <= n_out_removed;
        r_out_count   <= n_out_count;
    end

    assign i_cmd.ready         = (r_state == S_IDLE) && (r_fin == D_BUSY);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.removed_value = r_out_removed;
    assign o_rsp.element_count = r_out_count;

endmodule

// File: hdl/bde_ram.sv
// -----------------------------------------------------------------------------
// bde_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module bde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/bde_checker.sv
// -----------------------------------------------------------------------------
// bde_checker
// Port-level checks of the bounded deque engine, bound to the top level.
// -----------------------------------------------------------------------------
`include "bounded_deque_engine_assert.svh"

module bde_checker import bde_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_cmd_valid,
    input logic    i_cmd_ready,
    input logic    i_rsp_valid,
    input logic    i_rsp_ready,
    input t_status i_rsp_status,
    input t_value  i_rsp_removed,
    input t_count  i_rsp_count
);

    logic cmd_fire;
    logic count_ok;
    logic rsp_clear;
    logic rsp_empty;
    logic empty_ok;
    logic rsp_full;
    logic full_ok;
    logic rsp_miss;

    assign cmd_fire  = i_cmd_valid && i_cmd_ready;
    assign count_ok  = (CAPACITY > 31) || (i_rsp_count <= CAPACITY);
    assign rsp_clear = (i_rsp_removed == '0);
    assign rsp_empty = i_rsp_valid && (i_rsp_status == ST_EMPTY);
    assign empty_ok  = (i_rsp_count == '0) && rsp_clear;
    assign rsp_full  = i_rsp_valid && (i_rsp_status == ST_FULL);
    assign full_ok   = rsp_clear && ((CAPACITY > 31) || (i_rsp_count == CAPACITY));
    assign rsp_miss  = i_rsp_valid && i_rsp_ready && (i_rsp_status == ST_NOT_FOUND);

    // one command at a time: the sequencer is busy right after taking an item
    `BDE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, cmd_fire, !i_cmd_ready, "no busy cycle")

    `BDE_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, i_rsp_valid, count_ok, "count above capacity")

    `BDE_ASSERT_NOW(a_empty_consistent, i_clk, i_rst_n, rsp_empty, empty_ok, "bad empty item")

    `BDE_ASSERT_NOW(a_full_consistent, i_clk, i_rst_n, rsp_full, full_ok, "bad full item")

    `BDE_ASSERT_NOW(a_miss_clean, i_clk, i_rst_n, rsp_miss, rsp_clear, "miss with data")

endmodule

bind bounded_deque_engine bde_checker #(
    .CAPACITY (CAPACITY)
) u_bde_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cmd_valid   (i_cmd.valid),
    .i_cmd_ready   (i_cmd.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_status  (o_rsp.status),
    .i_rsp_removed (o_rsp.removed_value),
    .i_rsp_count   (o_rsp.element_count)
);
